>>> sv/rgbhsl_pkg.sv
// ----------------------------------------------------------------------------
// RGB565 to HSL package
// Shared types, constants, channel widening functions and the division step for the converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int DIV_STEPS   = 8;

  typedef enum logic [2:0] {
    SEL_RED   = 3'b001,
    SEL_GREEN = 3'b010,
    SEL_BLUE  = 3'b100
  } max_sel_t;

  typedef struct packed {
    logic [16:0] num_s;
    logic [8:0]  dv_s;
    logic [16:0] num_h;
    logic [8:0]  dv_h;
    logic        grey;
    logic [7:0]  light;
  } div_job_t;

  typedef struct packed {
    logic [8:0] rem;
    logic [7:0] lq;
    logic [8:0] dv;
  } div_state_t;

  // Widens a five-bit channel to trunc(c*255/31), taken as 8c + floor(7c/31).
  function automatic logic [7:0] widen5(input logic [4:0] c);
    logic [7:0]  x;
    logic [16:0] p;
    x = {c, 3'b000} - {3'b000, c};
    p = {9'b0, x} * 17'd265;
    return {c, 3'b000} + {5'b0, p[15:13]};
  endfunction

  // Widens a six-bit channel to trunc(c*255/63), taken as 4c + floor(c/21).
  function automatic logic [7:0] widen6(input logic [5:0] c);
    logic [1:0] k;
    if (c >= 6'd63) begin
      k = 2'd3;
    end else if (c >= 6'd42) begin
      k = 2'd2;
    end else if (c >= 6'd21) begin
      k = 2'd1;
    end else begin
      k = 2'd0;
    end
    return {c, 2'b00} + {6'b0, k};
  endfunction

  // One restoring division step producing one quotient bit.
  function automatic div_state_t div_step(input div_state_t s);
    div_state_t n;
    logic [9:0] t;
    logic [9:0] diff;
    t    = {s.rem, s.lq[7]};
    diff = t - {1'b0, s.dv};
    n.dv = s.dv;
    if (t >= {1'b0, s.dv}) begin
      n.rem = diff[8:0];
      n.lq  = {s.lq[6:0], 1'b1};
    end else begin
      n.rem = t[8:0];
      n.lq  = {s.lq[6:0], 1'b0};
    end
    return n;
  endfunction

endpackage

>>> sv/rgbhsl_if.sv
// ----------------------------------------------------------------------------
// RGB565 to HSL channel interfaces
// Valid/ready channels for the pixel input and the HSL result.
// ----------------------------------------------------------------------------
interface rgbhsl_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_565;

  modport source (output valid, output pixel_565, input ready);
  modport sink (input valid, input pixel_565, output ready);
endinterface

interface rgbhsl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness, input ready);
  modport sink (input valid, input hue, input saturation, input lightness, output ready);
endinterface

>>> sv/rgbhsl_front.sv
// ----------------------------------------------------------------------------
// RGB565 to HSL front end
// Widens the channels, classifies the maximum and prepares both divisions.
// ----------------------------------------------------------------------------
module rgbhsl_front (
  input  logic                 clk,
  input  logic                 rst_n,
  rgbhsl_in_if.sink            in_ch,
  output logic                 job_valid,
  input  logic                 job_ready,
  output rgbhsl_pkg::div_job_t job
);

  logic                 va_r, va_nxt;
  logic                 vb_r, vb_nxt;
  logic [7:0]           r_r, g_r, b_r, mx_r, mn_r;
  rgbhsl_pkg::max_sel_t sel_r;
  rgbhsl_pkg::div_job_t job_r;

  logic                 adv_a, adv_b;
  logic [7:0]           r_w, g_w, b_w, mx_w, mn_w;
  rgbhsl_pkg::max_sel_t sel_w;
  logic [8:0]           sum_w;
  logic [7:0]           d_w;
  logic [10:0]          d11_w, num_w;
  rgbhsl_pkg::div_job_t job_w;

  assign adv_b       = !vb_r || job_ready;
  assign adv_a       = !va_r || adv_b;
  assign in_ch.ready = adv_a;
  assign va_nxt      = in_ch.valid;
  assign vb_nxt      = va_r;
  assign job_valid   = vb_r;
  assign job         = job_r;

  always_comb begin
    r_w = rgbhsl_pkg::widen5(in_ch.pixel_565[15:11]);
    g_w = rgbhsl_pkg::widen6(in_ch.pixel_565[10:5]);
    b_w = rgbhsl_pkg::widen5(in_ch.pixel_565[4:0]);
    mx_w  = r_w;
    sel_w = rgbhsl_pkg::SEL_RED;
    if (g_w > mx_w) begin
      mx_w  = g_w;
      sel_w = rgbhsl_pkg::SEL_GREEN;
    end
    if (b_w > mx_w) begin
      mx_w  = b_w;
      sel_w = rgbhsl_pkg::SEL_BLUE;
    end
    mn_w = r_w;
    if (g_w < mn_w) begin
      mn_w = g_w;
    end
    if (b_w < mn_w) begin
      mn_w = b_w;
    end
  end

  always_comb begin
    sum_w = {1'b0, mx_r} + {1'b0, mn_r};
    d_w   = mx_r - mn_r;
    d11_w = {3'b000, d_w};
    case (sel_r)
      rgbhsl_pkg::SEL_RED: begin
        if (g_r < b_r) begin
          num_w = (d11_w << 2) + (d11_w << 1) + {3'b000, g_r} - {3'b000, b_r};
        end else begin
          num_w = {3'b000, g_r} - {3'b000, b_r};
        end
      end
      rgbhsl_pkg::SEL_GREEN: num_w = (d11_w << 1) + {3'b000, b_r} - {3'b000, r_r};
      rgbhsl_pkg::SEL_BLUE:  num_w = (d11_w << 2) + {3'b000, r_r} - {3'b000, g_r};
      default:               num_w = '0;
    endcase
    job_w.num_s = {9'b0, d_w} * 17'd255;
    job_w.dv_s  = (sum_w > 9'd255) ? 9'd510 - sum_w : sum_w;
    job_w.num_h = {6'b0, num_w} * 17'd85;
    job_w.dv_h  = {d_w, 1'b0};
    job_w.grey  = (mx_r == mn_r);
    job_w.light = sum_w[8:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (adv_a) begin
        va_r <= va_nxt;
      end
      if (adv_b) begin
        vb_r <= vb_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      r_r   <= r_w;
      g_r   <= g_w;
      b_r   <= b_w;
      mx_r  <= mx_w;
      mn_r  <= mn_w;
      sel_r <= sel_w;
    end
    if (adv_b) begin
      job_r <= job_w;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && !job_ready) |=> (vb_r && job_r == $past(job_r)))
    else $error("Front end job changed while stalled.");

endmodule

>>> sv/rgbhsl_queue.sv
// ----------------------------------------------------------------------------
// RGB565 to HSL job queue
// Short first-in first-out buffer between the front end and the dividers.
// ----------------------------------------------------------------------------
module rgbhsl_queue #(
  parameter int DEPTH = rgbhsl_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  rgbhsl_pkg::div_job_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output rgbhsl_pkg::div_job_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rgbhsl_pkg::div_job_t mem_r [0:DEPTH-1];
  logic [PW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("Queue fill count exceeds its depth.");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("Queue fill count did not follow a lone push.");

endmodule

>>> sv/rgbhsl_back.sv
// ----------------------------------------------------------------------------
// RGB565 to HSL back end
// Two pipelined restoring dividers giving saturation and hue.
// ----------------------------------------------------------------------------
module rgbhsl_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  rgbhsl_pkg::div_job_t job,
  rgbhsl_out_if.source         out_ch
);

  localparam int STEPS = rgbhsl_pkg::DIV_STEPS;

  typedef struct packed {
    rgbhsl_pkg::div_state_t sat;
    rgbhsl_pkg::div_state_t hue;
    logic                   grey;
    logic [7:0]             light;
  } stage_t;

  stage_t         stg_r [0:STEPS];
  logic [STEPS:0] v_r, v_nxt;
  logic           en;
  stage_t         first_w;

  assign en        = !v_r[STEPS] || out_ch.ready;
  assign job_ready = en;
  assign v_nxt     = {v_r[STEPS-1:0], job_valid};

  always_comb begin
    first_w.sat.rem = job.num_s[16:8];
    first_w.sat.lq  = job.num_s[7:0];
    first_w.sat.dv  = job.dv_s;
    first_w.hue.rem = job.num_h[16:8];
    first_w.hue.lq  = job.num_h[7:0];
    first_w.hue.dv  = job.dv_h;
    first_w.grey    = job.grey;
    first_w.light   = job.light;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0] <= first_w;
      for (int i = 0; i < STEPS; i++) begin
        stg_r[i+1].sat   <= rgbhsl_pkg::div_step(stg_r[i].sat);
        stg_r[i+1].hue   <= rgbhsl_pkg::div_step(stg_r[i].hue);
        stg_r[i+1].grey  <= stg_r[i].grey;
        stg_r[i+1].light <= stg_r[i].light;
      end
    end
  end

  assign out_ch.valid      = v_r[STEPS];
  assign out_ch.hue        = stg_r[STEPS].grey ? 8'd0 : stg_r[STEPS].hue.lq;
  assign out_ch.saturation = stg_r[STEPS].grey ? 8'd0 : stg_r[STEPS].sat.lq;
  assign out_ch.lightness  = stg_r[STEPS].light;

  a_black_is_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.lightness == 8'd0) |->
      (out_ch.hue == 8'd0 && out_ch.saturation == 8'd0))
    else $error("Black pixel gave non-zero hue or saturation.");

  a_take_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && job_ready) |=> v_r[0])
    else $error("Job taken from the queue did not enter the dividers.");

endmodule

>>> sv/rgb565_to_hsl_converter.sv
// An accepted pixel beat reaches its result beat through the front-end registers, the queue and the divider stages.
// Throughput: one pixel per cycle when the output is not stalled, set by the one-bit-per-stage divider pipelines.
// The front end and the dividers stall apart; the queue between them absorbs the slack.
// Reset clears all valid flags and queue pointers at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// RGB565 to HSL converter
// Converts RGB565 pixels to hue, saturation and lightness on 0..255 scales.
// ----------------------------------------------------------------------------
module rgb565_to_hsl_converter #(
  parameter int QUEUE_DEPTH = rgbhsl_pkg::QUEUE_DEPTH
) (
  input logic          clk,
  input logic          rst_n,
  rgbhsl_in_if.sink    in_ch,
  rgbhsl_out_if.source out_ch
);

  logic                 fq_valid, fq_ready;
  logic                 qb_valid, qb_ready;
  rgbhsl_pkg::div_job_t fq_job, qb_job;

  rgbhsl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  rgbhsl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_job)
  );

  rgbhsl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .out_ch    (out_ch)
  );

endmodule
